@@ hdl/mprt_pkg.sv @@
// ----------------------------------------------------------------------------
// mprt_pkg
// Shared types, codes and helpers of the multipath prefix route table.
// ----------------------------------------------------------------------------
package mprt_pkg;

    localparam int DEF_TABLE_DEPTH    = 16;
    localparam int DEF_INTERFACE_BITS = 8;
    localparam int MAX_RESULTS        = 16;
    localparam int K_BITS             = $clog2(MAX_RESULTS + 1);
    localparam int IN_BITS            = 80;
    localparam int OUT_BITS           = 48;
    localparam logic [5:0] MAX_PLEN   = 6'd32;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_NO_ROUTE = 3'd1,
        ST_ADDED    = 3'd2,
        ST_DUP      = 3'd3,
        ST_FULL     = 3'd4,
        ST_REMOVED  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BEST,
        S_LOOK_END,
        S_EMIT,
        S_LAST,
        S_DUP,
        S_ADD,
        S_REM,
        S_COLLAPSE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;   // take payload and kill flag from the neighbor
        logic wr;     // write a new route into this cell
    } t_cell_ctl;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = 32'd0;
        end else if (len >= MAX_PLEN) begin
            m = 32'hffffffff;
        end else begin
            m = ~(32'hffffffff >> len);
        end
        return m;
    endfunction

endpackage

@@ hdl/mprt_cell.sv @@
// ----------------------------------------------------------------------------
// mprt_cell
// One route slot of the table chain, shifted from its neighbor on request.
// ----------------------------------------------------------------------------
module mprt_cell #(
    parameter int INTERFACE_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mprt_pkg::t_cell_ctl       i_ctl,
    input  logic [31:0]               i_nb_net,
    input  logic [5:0]                i_nb_plen,
    input  logic [INTERFACE_BITS-1:0] i_nb_itf,
    input  logic [31:0]               i_nb_met,
    input  logic                      i_nb_kill,
    input  logic [31:0]               i_wr_net,
    input  logic [5:0]                i_wr_plen,
    input  logic [INTERFACE_BITS-1:0] i_wr_itf,
    input  logic [31:0]               i_wr_met,
    output logic [31:0]               o_net,
    output logic [5:0]                o_plen,
    output logic [INTERFACE_BITS-1:0] o_itf,
    output logic [31:0]               o_met,
    output logic                      o_kill
);
    import mprt_pkg::*;

    logic [31:0]               r_net;
    logic [5:0]                r_plen;
    logic [INTERFACE_BITS-1:0] r_itf;
    logic [31:0]               r_met;
    logic                      r_kill;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_net  <= i_nb_net;
            r_plen <= i_nb_plen;
            r_itf  <= i_nb_itf;
            r_met  <= i_nb_met;
        end else if (i_ctl.wr) begin
            r_net  <= i_wr_net;
            r_plen <= i_wr_plen;
            r_itf  <= i_wr_itf;
            r_met  <= i_wr_met;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill <= 1'b0;
        end else if (i_ctl.load) begin
            r_kill <= i_nb_kill;
        end else if (i_ctl.wr) begin
            r_kill <= 1'b0;
        end
    end

    assign o_net  = r_net;
    assign o_plen = r_plen;
    assign o_itf  = r_itf;
    assign o_met  = r_met;
    assign o_kill = r_kill;

endmodule

@@ hdl/multipath_prefix_route_table.sv @@
// ----------------------------------------------------------------------------
// multipath_prefix_route_table
// Ordered IPv4 route table with longest-prefix, lowest-metric multipath lookup.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: operation, address, prefix length,
// interface and metric packed in tdata. Results leave on the m_axis channel
// as status, interface, metric and removed count, tlast on the final result
// of a request. The routes sit in a ring of TABLE_DEPTH cells that rotates
// one slot per cycle past a head cell, where all compares are made, unless
// a stalled receiver holds it. A lookup makes one rotation to find the best
// prefix and metric and, if a route matches, a second to emit the best
// routes in order. An add makes a duplicate-scan rotation, then a write and
// a response; a remove makes a marking rotation, then a collapse pass that
// closes one gap per cycle. One request is in work at a time; tready is
// high only while the table is idle. A stalled receiver freezes the emit
// rotation and holds the output register. Reset empties the table (route
// count zero) and drops any result in flight.
// ----------------------------------------------------------------------------
module multipath_prefix_route_table #(
    parameter int TABLE_DEPTH    = mprt_pkg::DEF_TABLE_DEPTH,
    parameter int INTERFACE_BITS = mprt_pkg::DEF_INTERFACE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // operation[1:0], address[33:2], prefix_length[39:34],
    // out_interface[47:40], route_metric[79:48]
    input  logic [mprt_pkg::IN_BITS-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // status[2:0], chosen_interface[10:3], chosen_metric[42:11],
    // removed_count[47:43]
    output logic [mprt_pkg::OUT_BITS-1:0] o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);
    import mprt_pkg::*;

    localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int IFW = INTERFACE_BITS;

    t_state r_state, n_state;

    logic [IW-1:0]  r_step;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_kept;
    logic [31:0]    r_addr;
    logic [5:0]     r_plen;
    logic [IFW-1:0] r_itf;
    logic [31:0]    r_met;
    logic           r_any;
    logic [5:0]     r_best_len;
    logic [31:0]    r_best_met;
    logic           r_dup;
    logic [4:0]     r_rem;
    t_status        r_rstat;
    logic           r_pend_v;
    logic [IFW-1:0] r_pend_itf;
    logic [31:0]    r_pend_met;
    logic [K_BITS-1:0] r_k;
    logic                r_ovalid;
    logic [OUT_BITS-1:0] r_odata;
    logic                r_olast;

    logic [31:0]    w_net  [TABLE_DEPTH];
    logic [5:0]     w_plen [TABLE_DEPTH];
    logic [IFW-1:0] w_itf  [TABLE_DEPTH];
    logic [31:0]    w_met  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_kill;
    logic [TABLE_DEPTH-1:0] w_pre;

    logic        w_in_acc, w_ofree, w_last_step, w_head_valid;
    logic        w_pfx_hit, w_dup_hit, w_rem_hit, w_best_hit;
    logic        w_rotate, w_collapse, w_write, w_push;
    logic [31:0] w_mask, w_rem_mask;
    logic [5:0]  w_in_plen;
    t_op         w_in_op;
    logic [OUT_BITS-1:0] w_push_data;
    logic        w_push_last;
    logic [15:0] w_pend_itf16;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_op   = t_op'(i_s_axis_tdata[1:0]);
    assign w_in_plen = (i_s_axis_tdata[39:34] > MAX_PLEN) ? MAX_PLEN : i_s_axis_tdata[39:34];
    assign w_ofree   = !r_ovalid || i_m_axis_tready;
    assign w_last_step = (r_step == IW'(TABLE_DEPTH - 1));
    assign w_head_valid = (CW'(r_step) < r_count);

    // compares at the head of the ring
    assign w_mask     = prefix_mask(w_plen[0]);
    assign w_rem_mask = prefix_mask(r_plen);
    assign w_pfx_hit  = w_head_valid && (((r_addr ^ w_net[0]) & w_mask) == 32'd0);
    assign w_dup_hit  = w_head_valid && (w_net[0] == r_addr) && (w_plen[0] == r_plen)
                        && (w_itf[0] == r_itf) && (w_met[0] == r_met);
    assign w_rem_hit  = w_head_valid && (w_itf[0] == r_itf) && (w_plen[0] == r_plen)
                        && (((w_net[0] ^ r_addr) & w_rem_mask) == 32'd0);
    assign w_best_hit = w_pfx_hit && (w_plen[0] == r_best_len) && (w_met[0] == r_best_met)
                        && (r_k < K_BITS'(MAX_RESULTS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_in_op)
                        OP_LOOKUP: n_state = S_BEST;
                        OP_ADD:    n_state = S_DUP;
                        OP_REMOVE: n_state = S_REM;
                        OP_NOP:    n_state = S_IDLE;
                    endcase
                end
            end
            S_BEST:     if (w_last_step) n_state = S_LOOK_END;
            S_LOOK_END: n_state = r_any ? S_EMIT : S_RESP;
            S_EMIT:     if (w_ofree && w_last_step) n_state = S_LAST;
            S_LAST:     if (w_ofree) n_state = S_IDLE;
            S_DUP:      if (w_last_step) n_state = S_ADD;
            S_ADD:      n_state = S_RESP;
            S_REM:      if (w_last_step) n_state = S_COLLAPSE;
            S_COLLAPSE: if (w_last_step) n_state = S_RESP;
            S_RESP:     if (w_ofree) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        w_rotate    = 1'b0;
        w_collapse  = 1'b0;
        w_write     = 1'b0;
        w_push      = 1'b0;
        w_push_last = 1'b1;
        w_pend_itf16 = 16'(r_pend_itf);
        w_push_data = {r_rem, 32'd0, 8'd0, r_rstat};
        unique case (r_state)
            S_BEST, S_DUP, S_REM: w_rotate = 1'b1;
            S_EMIT: begin
                w_rotate    = w_ofree;
                w_push      = w_ofree && w_best_hit && r_pend_v;
                w_push_last = 1'b0;
                w_push_data = {5'd0, r_pend_met, w_pend_itf16[7:0], ST_FOUND};
            end
            S_LAST: begin
                w_push      = w_ofree;
                w_push_data = {5'd0, r_pend_met, w_pend_itf16[7:0], ST_FOUND};
            end
            S_ADD:      w_write = !r_dup && (r_count < CW'(TABLE_DEPTH));
            S_COLLAPSE: w_collapse = 1'b1;
            S_RESP:     w_push = w_ofree;
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pend_v <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            if (w_rotate || w_collapse) begin
                r_step <= w_last_step ? '0 : r_step + 1'b1;
            end
            if (w_write) begin
                r_count <= r_count + 1'b1;
            end else if (w_collapse && w_last_step) begin
                r_count <= r_kept;
            end
            if (w_in_acc) begin
                r_pend_v <= 1'b0;
                r_k      <= '0;
            end else if (r_state == S_EMIT && w_ofree && w_best_hit) begin
                r_pend_v <= 1'b1;
                r_k      <= r_k + 1'b1;
            end
            if (w_push) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // request fields and scan results
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr <= i_s_axis_tdata[33:2];
            r_plen <= w_in_plen;
            r_itf  <= IFW'(16'(i_s_axis_tdata[47:40]));
            r_met  <= i_s_axis_tdata[79:48];
            r_any  <= 1'b0;
            r_dup  <= 1'b0;
            r_rem  <= '0;
            r_kept <= '0;
        end
        if (r_state == S_BEST && w_pfx_hit) begin
            if (!r_any || w_plen[0] > r_best_len) begin
                r_any      <= 1'b1;
                r_best_len <= w_plen[0];
                r_best_met <= w_met[0];
            end else if (w_plen[0] == r_best_len && w_met[0] < r_best_met) begin
                r_best_met <= w_met[0];
            end
        end
        if (r_state == S_DUP && w_dup_hit) begin
            r_dup <= 1'b1;
        end
        if (r_state == S_REM && w_head_valid) begin
            if (w_rem_hit) begin
                r_rem <= r_rem + 1'b1;
            end else begin
                r_kept <= r_kept + 1'b1;
            end
        end
        if (r_state == S_LOOK_END) begin
            r_rstat <= ST_NO_ROUTE;
        end else if (r_state == S_ADD) begin
            if (r_dup) begin
                r_rstat <= ST_DUP;
            end else if (r_count >= CW'(TABLE_DEPTH)) begin
                r_rstat <= ST_FULL;
            end else begin
                r_rstat <= ST_ADDED;
            end
        end else if (r_state == S_COLLAPSE) begin
            r_rstat <= ST_REMOVED;
        end
        if (r_state == S_EMIT && w_ofree && w_best_hit) begin
            r_pend_itf <= w_itf[0];
            r_pend_met <= w_met[0];
        end
        if (w_push) begin
            r_odata <= w_push_data;
            r_olast <= w_push_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    // ring of route cells; collapse shifts everything above the first gap
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            t_cell_ctl      w_ctl;
            logic [31:0]    w_nb_net;
            logic [5:0]     w_nb_plen;
            logic [IFW-1:0] w_nb_itf;
            logic [31:0]    w_nb_met;
            logic           w_nb_kill;

            if (gi == 0) begin : g_pre0
                assign w_pre[gi] = w_kill[gi];
            end else begin : g_pre
                assign w_pre[gi] = w_pre[gi-1] | w_kill[gi];
            end

            if (gi == TABLE_DEPTH - 1) begin : g_tail
                assign w_nb_net  = w_net[0];
                assign w_nb_plen = w_plen[0];
                assign w_nb_itf  = w_itf[0];
                assign w_nb_met  = w_met[0];
                assign w_nb_kill = (r_state == S_REM) && w_rem_hit;
            end else begin : g_body
                assign w_nb_net  = w_net[gi+1];
                assign w_nb_plen = w_plen[gi+1];
                assign w_nb_itf  = w_itf[gi+1];
                assign w_nb_met  = w_met[gi+1];
                assign w_nb_kill = w_kill[gi+1];
            end

            assign w_ctl.load = w_rotate || (w_collapse && w_pre[gi]);
            assign w_ctl.wr   = w_write && (r_count[IW-1:0] == IW'(gi));

            mprt_cell #(
                .INTERFACE_BITS(IFW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_nb_net  (w_nb_net),
                .i_nb_plen (w_nb_plen),
                .i_nb_itf  (w_nb_itf),
                .i_nb_met  (w_nb_met),
                .i_nb_kill (w_nb_kill),
                .i_wr_net  (r_addr),
                .i_wr_plen (r_plen),
                .i_wr_itf  (r_itf),
                .i_wr_met  (r_met),
                .o_net     (w_net[gi]),
                .o_plen    (w_plen[gi]),
                .o_itf     (w_itf[gi]),
                .o_met     (w_met[gi]),
                .o_kill    (w_kill[gi])
            );
        end
    endgenerate

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("route count above table depth");

    a_no_kill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_kill == '0))
        else $error("removal marks left after collapse");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= K_BITS'(MAX_RESULTS))
        else $error("too many lookup results");

    a_emit_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_any)
        else $error("emit pass without a best route");

endmodule

@@ verif/multipath_prefix_route_table_tb.sv @@
// ----------------------------------------------------------------------------
// multipath_prefix_route_table_tb
// Self-checking bench for the route table: directed add, remove and lookup
// requests, then random ones built on a small pool of networks, checked
// against a behavioral copy of the table with random stalls on both sides.
// ----------------------------------------------------------------------------
module multipath_prefix_route_table_tb;
    import mprt_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  itf;
        logic [31:0] metric;
        logic [4:0]  removed;
        logic        last;
    } t_route_rsp;

    typedef struct packed {
        logic              drain_first;
        logic [IN_BITS-1:0] data;
    } t_req_slot;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [IN_BITS-1:0]  i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OUT_BITS-1:0] o_m_axis_tdata;
    logic                o_m_axis_tlast;

    multipath_prefix_route_table uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // shadow route table
    logic [31:0] tbl_net [16];
    logic [5:0]  tbl_plen [16];
    logic [7:0]  tbl_itf [16];
    logic [31:0] tbl_met [16];
    int          tbl_count;

    t_req_slot  req_queue[$];
    t_route_rsp rsp_queue[$];

    int  mismatches;
    int  unexpected;
    int  rsp_checked;
    int  req_accepted;
    int  found_seen;
    int  full_seen;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  hold_cycles;
    logic in_fire;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] route_mask(input logic [5:0] len);
        if (len == 6'd0) return 32'd0;
        if (len >= 6'd32) return 32'hffffffff;
        return 32'hffffffff << (32 - len);
    endfunction

    function automatic t_route_rsp mk_rsp(input t_status st, input logic [7:0] itf,
                                          input logic [31:0] met, input logic [4:0] rc,
                                          input logic last);
        t_route_rsp r;
        r.status  = st;
        r.itf     = itf;
        r.metric  = met;
        r.removed = rc;
        r.last    = last;
        return r;
    endfunction

    task automatic add_expected(input t_route_rsp r);
        rsp_queue = {rsp_queue, r};
    endtask

    task automatic predict_route_rsp(input logic [IN_BITS-1:0] d);
        t_op         op;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic [7:0]  itf;
        logic [31:0] met;
        logic [31:0] m;
        logic        any;
        logic [5:0]  best_len;
        logic [31:0] best_met;
        int          k;
        int          w;
        int          removed;
        bit          dup;
        op   = t_op'(d[1:0]);
        addr = d[33:2];
        plen = (d[39:34] > 6'd32) ? 6'd32 : d[39:34];
        itf  = d[47:40];
        met  = d[79:48];
        case (op)
            OP_LOOKUP: begin
                any = 1'b0;
                best_len = 6'd0;
                best_met = 32'hffffffff;
                for (int i = 0; i < tbl_count; i++) begin
                    m = route_mask(tbl_plen[i]);
                    if ((addr & m) != (tbl_net[i] & m)) continue;
                    // a longer prefix discards all shorter matches
                    if (!any || tbl_plen[i] > best_len) begin
                        any = 1'b1;
                        best_len = tbl_plen[i];
                        best_met = tbl_met[i];
                    end else if (tbl_plen[i] == best_len && tbl_met[i] < best_met) begin
                        best_met = tbl_met[i];
                    end
                end
                if (!any) begin
                    add_expected(mk_rsp(ST_NO_ROUTE, 8'd0, 32'd0, 5'd0, 1'b1));
                end else begin
                    k = 0;
                    for (int i = 0; i < tbl_count && k < MAX_RESULTS; i++) begin
                        m = route_mask(tbl_plen[i]);
                        if ((addr & m) != (tbl_net[i] & m)) continue;
                        if (tbl_plen[i] != best_len || tbl_met[i] != best_met) continue;
                        add_expected(mk_rsp(ST_FOUND, tbl_itf[i], tbl_met[i],
                                            5'd0, 1'b0));
                        k++;
                    end
                    rsp_queue[$].last = 1'b1;
                end
            end
            OP_ADD: begin
                dup = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_net[i] == addr && tbl_plen[i] == plen &&
                        tbl_itf[i] == itf && tbl_met[i] == met) dup = 1;
                end
                if (dup) begin
                    add_expected(mk_rsp(ST_DUP, 8'd0, 32'd0, 5'd0, 1'b1));
                end else if (tbl_count >= 16) begin
                    add_expected(mk_rsp(ST_FULL, 8'd0, 32'd0, 5'd0, 1'b1));
                end else begin
                    tbl_net[tbl_count]  = addr;
                    tbl_plen[tbl_count] = plen;
                    tbl_itf[tbl_count]  = itf;
                    tbl_met[tbl_count]  = met;
                    tbl_count++;
                    add_expected(mk_rsp(ST_ADDED, 8'd0, 32'd0, 5'd0, 1'b1));
                end
            end
            OP_REMOVE: begin
                m = route_mask(plen);
                w = 0;
                removed = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_itf[i] == itf && tbl_plen[i] == plen &&
                        (tbl_net[i] & m) == (addr & m)) begin
                        removed++;
                    end else begin
                        tbl_net[w]  = tbl_net[i];
                        tbl_plen[w] = tbl_plen[i];
                        tbl_itf[w]  = tbl_itf[i];
                        tbl_met[w]  = tbl_met[i];
                        w++;
                    end
                end
                tbl_count = w;
                add_expected(mk_rsp(ST_REMOVED, 8'd0, 32'd0, removed[4:0], 1'b1));
            end
            default: ;
        endcase
    endtask

    function automatic logic [IN_BITS-1:0] mk_req(input t_op op, input logic [31:0] addr,
                                                  input logic [5:0] plen,
                                                  input logic [7:0] itf,
                                                  input logic [31:0] met);
        return {met, itf, plen, addr, op};
    endfunction

    task automatic push_req(input logic [IN_BITS-1:0] d, input logic drain);
        t_req_slot s;
        s.drain_first = drain;
        s.data = d;
        req_queue = {req_queue, s};
    endtask

    task automatic push_random_reqs(input int n);
        logic [31:0] pool [4];
        logic [5:0]  plen_pick [6];
        logic [31:0] addr;
        logic [5:0]  plen;
        logic [7:0]  itf;
        logic [31:0] met;
        int          r;
        pool[0] = 32'h0a000000;
        pool[1] = 32'h0a010000;
        pool[2] = 32'hc0a80100;
        pool[3] = 32'hffffff00;
        plen_pick[0] = 6'd0;
        plen_pick[1] = 6'd8;
        plen_pick[2] = 6'd16;
        plen_pick[3] = 6'd24;
        plen_pick[4] = 6'd32;
        plen_pick[5] = 6'd12;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            addr = pool[$urandom_range(0, 3)] | ($urandom & 32'h000003ff);
            if ($urandom_range(0, 9) == 0) addr = $urandom;
            plen = plen_pick[$urandom_range(0, 5)];
            if ($urandom_range(0, 11) == 0) plen = 6'($urandom_range(0, 63));
            itf = 8'($urandom_range(0, 5));
            if ($urandom_range(0, 9) == 0) itf = 8'($urandom);
            met = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) met = $urandom;
            if (r < 40) begin
                push_req(mk_req(OP_LOOKUP, addr, 6'($urandom), 8'($urandom), $urandom), 1'b0);
            end else if (r < 75) begin
                push_req(mk_req(OP_ADD, addr, plen, itf, met), 1'b0);
            end else if (r < 97) begin
                push_req(mk_req(OP_REMOVE, addr, plen, itf, $urandom), 1'b0);
            end else begin
                push_req(mk_req(OP_NOP, $urandom, 6'($urandom), 8'($urandom), $urandom),
                         1'b0);
            end
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_fire) begin
            if (req_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct &&
                (!req_queue[0].drain_first || rsp_queue.size() == 0)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= req_queue[0].data;
                req_queue.delete(0);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_m_axis_tready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // acceptance, prediction and result check
    always @(posedge i_clk) begin
        t_route_rsp got;
        t_route_rsp want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_route_rsp(i_s_axis_tdata);
                req_accepted++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = mk_rsp(t_status'(o_m_axis_tdata[2:0]), o_m_axis_tdata[10:3],
                             o_m_axis_tdata[42:11], o_m_axis_tdata[47:43], o_m_axis_tlast);
                if (rsp_queue.size() == 0) begin
                    unexpected++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: st=%0d itf=%0d met=%0d rc=%0d last=%0b",
                                 got.status, got.itf, got.metric, got.removed, got.last);
                end else begin
                    want = rsp_queue.pop_front();
                    rsp_checked++;
                    if (got.status == ST_FOUND) found_seen++;
                    if (got.status == ST_FULL) full_seen++;
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: exp st=%0d itf=%0d met=%0d rc=%0d last=%0b",
                                   want.status, want.itf, want.metric, want.removed,
                                   want.last);
                            $display(" got st=%0d itf=%0d met=%0d rc=%0d last=%0b",
                                     got.status, got.itf, got.metric, got.removed,
                                     got.last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        tbl_count = 0;
        mismatches = 0;
        unexpected = 0;
        rsp_checked = 0;
        req_accepted = 0;
        found_seen = 0;
        full_seen = 0;
        hold_cycles = 0;
        sender_idle_pct = 35;
        receiver_idle_pct = 60;

        // directed part
        push_req(mk_req(OP_LOOKUP, 32'h0a010203, 6'd0, 8'd0, 32'd0), 1'b0);
        push_req(mk_req(OP_ADD, 32'h00000000, 6'd0, 8'd1, 32'd5), 1'b0);
        push_req(mk_req(OP_ADD, 32'h00000000, 6'd0, 8'd1, 32'd5), 1'b0);
        push_req(mk_req(OP_ADD, 32'h0a000000, 6'd8, 8'd2, 32'd7), 1'b0);
        push_req(mk_req(OP_ADD, 32'h0a010000, 6'd16, 8'd3, 32'd9), 1'b0);
        push_req(mk_req(OP_ADD, 32'h0a010000, 6'd16, 8'd4, 32'd9), 1'b0);
        push_req(mk_req(OP_LOOKUP, 32'h0a010203, 6'd63, 8'hff, 32'hffffffff), 1'b0);
        push_req(mk_req(OP_LOOKUP, 32'h0a020001, 6'd0, 8'd0, 32'd0), 1'b0);
        push_req(mk_req(OP_LOOKUP, 32'h0b000000, 6'd0, 8'd0, 32'd0), 1'b0);
        // prefix above 32 is clamped on store
        push_req(mk_req(OP_ADD, 32'hffffffff, 6'd63, 8'hff, 32'hffffffff), 1'b0);
        push_req(mk_req(OP_LOOKUP, 32'hffffffff, 6'd0, 8'd0, 32'd0), 1'b0);
        push_req(mk_req(OP_REMOVE, 32'h0a01ffff, 6'd16, 8'd3, 32'd0), 1'b0);
        push_req(mk_req(OP_NOP, 32'hffffffff, 6'd63, 8'hff, 32'hffffffff), 1'b0);
        push_req(mk_req(OP_REMOVE, 32'h12345678, 6'd0, 8'd1, 32'd0), 1'b0);
        for (int i = 0; i < 13; i++)
            push_req(mk_req(OP_ADD, 32'h0, 6'd0, i[7:0], 32'd0), 1'b0);
        push_req(mk_req(OP_ADD, 32'h01020304, 6'd24, 8'd9, 32'd1), 1'b0);
        push_req(mk_req(OP_ADD, 32'h0, 6'd0, 8'd5, 32'd0), 1'b0);
        push_req(mk_req(OP_LOOKUP, 32'h00000001, 6'd0, 8'd0, 32'd0), 1'b0);
        push_random_reqs(80);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (req_queue.size() == 0);
        sender_idle_pct = 60;
        receiver_idle_pct = 35;
        // hold off the table until every pending result has come
        push_req(mk_req(OP_LOOKUP, 32'h0a010101, 6'd0, 8'd0, 32'd0), 1'b1);
        push_random_reqs(90);

        wait (req_queue.size() == 0);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        push_random_reqs(90);
        @(negedge i_clk);
        hold_cycles = 400;

        wait (req_queue.size() == 0 && rsp_queue.size() == 0);
        repeat (100) @(posedge i_clk);

        $display("requests accepted: %0d, results checked: %0d (%0d routes, %0d table-full)",
                 req_accepted, rsp_checked, found_seen, full_seen);
        if (mismatches == 0 && rsp_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("mismatches: %0d, unexpected: %0d", mismatches, unexpected);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ multipath_prefix_route_table.f @@
hdl/mprt_pkg.sv
hdl/mprt_cell.sv
hdl/multipath_prefix_route_table.sv
verif/multipath_prefix_route_table_tb.sv
